>>> rtl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared constants and types of the RGB to HSV converter
// Component and fraction widths, divider slicing and the beat format that
// travels down the divider stages.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int FRACTION_BITS  = 16;

    // quotient bits resolved per divider stage; must divide FRACTION_BITS
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = FRACTION_BITS / DIV_BITS;

    // 6 * delta stays below 2^(COMPONENT_BITS + 3)
    localparam int HDIV_W = COMPONENT_BITS + 3;

    typedef logic [COMPONENT_BITS-1:0] t_comp;
    typedef logic [FRACTION_BITS-1:0]  t_frac;
    typedef logic [HDIV_W-1:0]         t_hdiv;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    // first stage: extremes and the raw components
    typedef struct packed {
        t_comp   red;
        t_comp   green;
        t_comp   blue;
        t_comp   hi;
        t_comp   lo;
        t_sector sector;
    } t_mm_data;

    // divider stages: two restoring divisions side by side
    typedef struct packed {
        t_hdiv hue_rem;
        t_hdiv hue_den;
        t_frac hue_q;
        t_comp sat_rem;
        t_comp sat_den;
        t_frac sat_q;
        t_comp brightness;
        logic  gray;
        logic  sat_full;
    } t_div_data;

endpackage

>>> rtl/rth_rgb_if.sv
// ----------------------------------------------------------------------------
// rth_rgb_if: pixel input channel
// Valid/ready handshake carrying one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface rth_rgb_if;
    import rth_pkg::*;

    logic  valid;
    logic  ready;
    t_comp red;
    t_comp green;
    t_comp blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/rth_hsv_if.sv
// ----------------------------------------------------------------------------
// rth_hsv_if: HSV result channel
// Valid/ready handshake carrying hue, saturation and value per beat.
// ----------------------------------------------------------------------------
interface rth_hsv_if;
    import rth_pkg::*;

    logic  valid;
    logic  ready;
    t_frac hue;
    t_frac saturation;
    t_comp brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

>>> rtl/rgb_to_hsv_top.sv
// Pipeline: 2 front stages, DIV_STAGES = 8 divider stages of 2 quotient bits
//   and 1 output register lie between an accepted pixel beat and its result beat.
// Throughput: one pixel per cycle; the whole pipe advances together and
//   freezes while the output register holds a beat that is not taken.
// Reset: synchronous, active low; clears every valid bit, payload is left as is.
// ----------------------------------------------------------------------------
// rgb_to_hsv_top: pipelined RGB to HSV converter
// Value is the largest component, saturation (max-min)/max and hue the
// sector offset over 6*(max-min), both as truncated 16-bit fractions.
// ----------------------------------------------------------------------------
module rgb_to_hsv_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rth_rgb_if.sink    i_pix,
    rth_hsv_if.source  o_hsv
);
    import rth_pkg::*;

    // advance the whole pipe unless the output beat is stuck
    logic      w_adv;
    logic      w_valid [0:DIV_STAGES];
    t_div_data w_data  [0:DIV_STAGES];

    logic      r_out_valid;
    t_frac     r_hue;
    t_frac     r_sat;
    t_comp     r_bright;
    t_frac     n_hue;
    t_frac     n_sat;

    assign w_adv       = !r_out_valid || o_hsv.ready;
    assign i_pix.ready = w_adv;

    // extremes, sector and division operands
    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_pix.valid),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (w_valid[0]),
        .o_data  (w_data[0])
    );

    // chain of divider slices, each resolving DIV_BITS quotient bits
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        rth_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[s]),
            .i_data  (w_data[s]),
            .o_valid (w_valid[s+1]),
            .o_data  (w_data[s+1])
        );
    end

    // final fix-ups: black or gray drops hue and saturation to zero,
    // a zero minimum pins saturation at the top code
    always_comb begin
        if (w_data[DIV_STAGES].gray) begin
            n_hue = '0;
            n_sat = '0;
        end else if (w_data[DIV_STAGES].sat_full) begin
            n_hue = w_data[DIV_STAGES].hue_q;
            n_sat = '1;
        end else begin
            n_hue = w_data[DIV_STAGES].hue_q;
            n_sat = w_data[DIV_STAGES].sat_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= w_data[DIV_STAGES].brightness;
        end
    end

    assign o_hsv.valid      = r_out_valid;
    assign o_hsv.hue        = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.brightness = r_bright;

`ifndef NO_ASSERTIONS
    // a black pixel carries neither hue nor saturation
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && (o_hsv.brightness == '0) |-> (o_hsv.hue == '0) && (o_hsv.saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

    // zero saturation on a lit pixel only happens for gray, whose hue is zero
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && (o_hsv.brightness != '0) && (o_hsv.saturation == '0) |-> (o_hsv.hue == '0))
        else $error("gray pixel with nonzero hue");

    // a stalled pipe keeps its front and divider beats in place
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_valid[0]) && $stable(w_valid[DIV_STAGES]))
        else $error("pipeline beat moved during stall");
`endif

endmodule

>>> rtl/rth_front.sv
// ----------------------------------------------------------------------------
// rth_front: extremes, sector and division operands
// Two register stages: max/min/sector first, then delta, 6*delta, hue
// numerator and the special-case flags.
// ----------------------------------------------------------------------------
module rth_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  rth_pkg::t_comp     i_red,
    input  rth_pkg::t_comp     i_green,
    input  rth_pkg::t_comp     i_blue,
    output logic               o_valid,
    output rth_pkg::t_div_data o_data
);
    import rth_pkg::*;

    logic      r_mm_valid;
    t_mm_data  r_mm;
    t_mm_data  n_mm;
    logic      r_div_valid;
    t_div_data r_div;
    t_div_data n_div;

    // stage one: largest, smallest, sector (red wins ties, then green)
    always_comb begin
        n_mm.red   = i_red;
        n_mm.green = i_green;
        n_mm.blue  = i_blue;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_mm.sector = SECT_RED;
            n_mm.hi     = i_red;
        end else if (i_green >= i_blue) begin
            n_mm.sector = SECT_GREEN;
            n_mm.hi     = i_green;
        end else begin
            n_mm.sector = SECT_BLUE;
            n_mm.hi     = i_blue;
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            n_mm.lo = i_red;
        end else if (i_green <= i_blue) begin
            n_mm.lo = i_green;
        end else begin
            n_mm.lo = i_blue;
        end
    end

    // stage two: operands of both divisions
    always_comb begin
        t_comp delta;
        t_hdiv d_ext;
        t_hdiv six_delta;
        t_hdiv r_ext;
        t_hdiv g_ext;
        t_hdiv b_ext;

        delta     = r_mm.hi - r_mm.lo;
        d_ext     = HDIV_W'(delta);
        six_delta = (d_ext << 2) + (d_ext << 1);
        r_ext     = HDIV_W'(r_mm.red);
        g_ext     = HDIV_W'(r_mm.green);
        b_ext     = HDIV_W'(r_mm.blue);

        n_div            = '0;
        n_div.hue_den    = six_delta;
        n_div.sat_rem    = delta;
        n_div.sat_den    = r_mm.hi;
        n_div.brightness = r_mm.hi;
        n_div.gray       = (delta == '0);
        n_div.sat_full   = (r_mm.lo == '0) && (delta != '0);

        unique case (r_mm.sector)
            SECT_RED: begin
                // wrap a negative offset by one full turn
                if (g_ext >= b_ext) begin
                    n_div.hue_rem = g_ext - b_ext;
                end else begin
                    n_div.hue_rem = six_delta - (b_ext - g_ext);
                end
            end
            SECT_GREEN: begin
                n_div.hue_rem = (d_ext << 1) + b_ext - r_ext;
            end
            SECT_BLUE: begin
                n_div.hue_rem = (d_ext << 2) + r_ext - g_ext;
            end
            default: begin
                n_div.hue_rem = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_valid  <= 1'b0;
            r_div_valid <= 1'b0;
        end else if (i_adv) begin
            r_mm_valid  <= i_valid;
            r_div_valid <= r_mm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mm  <= n_mm;
            r_div <= n_div;
        end
    end

    assign o_valid = r_div_valid;
    assign o_data  = r_div;

endmodule

>>> rtl/rth_div_stage.sv
// ----------------------------------------------------------------------------
// rth_div_stage: one slice of the pipelined restoring dividers
// Resolves DIV_BITS quotient bits of hue and of saturation per stage.
// ----------------------------------------------------------------------------
module rth_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  rth_pkg::t_div_data i_data,
    output logic               o_valid,
    output rth_pkg::t_div_data o_data
);
    import rth_pkg::*;

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;

    always_comb begin
        logic [HDIV_W:0]         hue_sh;
        logic [COMPONENT_BITS:0] sat_sh;
        logic                    hue_bit;
        logic                    sat_bit;

        n_data = i_data;
        for (int k = 0; k < DIV_BITS; k++) begin
            hue_sh = {n_data.hue_rem, 1'b0};
            if (hue_sh >= {1'b0, n_data.hue_den}) begin
                hue_sh  = hue_sh - {1'b0, n_data.hue_den};
                hue_bit = 1'b1;
            end else begin
                hue_bit = 1'b0;
            end
            n_data.hue_rem = hue_sh[HDIV_W-1:0];
            n_data.hue_q   = {n_data.hue_q[FRACTION_BITS-2:0], hue_bit};

            sat_sh = {n_data.sat_rem, 1'b0};
            if (sat_sh >= {1'b0, n_data.sat_den}) begin
                sat_sh  = sat_sh - {1'b0, n_data.sat_den};
                sat_bit = 1'b1;
            end else begin
                sat_bit = 1'b0;
            end
            n_data.sat_rem = sat_sh[COMPONENT_BITS-1:0];
            n_data.sat_q   = {n_data.sat_q[FRACTION_BITS-2:0], sat_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
